// File: hw/rtl/interest_list_change_coalescer_top_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef INTEREST_LIST_CHANGE_COALESCER_TOP_ASSERT_SVH
`define INTEREST_LIST_CHANGE_COALESCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ILCC_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("ilcc check failed");
`define ILCC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ilcc check failed");
`else
`define ILCC_ASSERT(lbl, clk, rstn, expr)
`define ILCC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/ilcc_pkg.sv
package ilcc_pkg;

    localparam int DEF_MAX_HANDLES = 1024;
    localparam int DEF_SLOT_COUNT  = 64;

    localparam int HDL_W = 10;
    localparam int EV_W  = 32;
    localparam int TAG_W = 48;
    localparam int ID_W  = 32;
    localparam int CNT_W = 7;
    localparam int KEY_W = 1 + HDL_W + ID_W;

    localparam logic [CNT_W-1:0] NOSLOT = 7'd127;

    typedef enum logic [1:0] {
        OPC_ASSOC  = 2'd0,
        OPC_DISSOC = 2'd1,
        OPC_FLUSH  = 2'd2,
        OPC_RSVD   = 2'd3
    } t_opc;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_MOD  = 2'd2,
        CMD_DEL  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        K_WRA,
        K_SWAP,
        K_DROP
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_RDA,
        S_DEC,
        S_RDB,
        S_RDC,
        S_WR,
        S_FIDX,
        S_FRD
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] ckey;
        logic [TAG_W-1:0] ctag;
        logic [EV_W-1:0]  cev;
        logic [HDL_W-1:0] ph;
        logic [ID_W-1:0]  pid;
        logic [EV_W-1:0]  pev;
        logic [TAG_W-1:0] ptag;
        t_cmd             pop;
    } t_slot;

endpackage

// File: hw/rtl/ilcc_ram.sv
module ilcc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/interest_list_change_coalescer_top.sv
// Interest list change coalescer. After reset the block sweeps the handle
// map with busy high. An associate or dissociate that is a no-op from the
// start, such as an already fired associate, and a flush with nothing
// pending are answered straight from idle. Other operations, and a flush for
// each pending slot, work through the single read and write port of the slot
// memory: every slot read, swap and copy goes through it one word a cycle.
// Results come as one-cycle strobes on o_valid and must be taken when shown;
// the receiver cannot stall.
`include "interest_list_change_coalescer_top_assert.svh"
module interest_list_change_coalescer_top
    import ilcc_pkg::*;
#(
    parameter int MAX_HANDLES = DEF_MAX_HANDLES,
    parameter int SLOT_COUNT  = DEF_SLOT_COUNT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_opcode,
    input  logic [HDL_W-1:0] i_handle,
    input  logic [EV_W-1:0]  i_event_mask,
    input  logic [TAG_W-1:0] i_user_tag,
    input  logic [ID_W-1:0]  i_owner_id,
    input  logic             i_already_fired,
    output logic             o_valid,
    output logic             o_status,
    output logic [1:0]       o_command,
    output logic [HDL_W-1:0] o_cmd_handle,
    output logic [EV_W-1:0]  o_cmd_events,
    output logic [TAG_W-1:0] o_cmd_tag,
    output logic             o_last
);

    localparam int MW = $clog2(MAX_HANDLES);
    localparam int SW = $clog2(SLOT_COUNT);
    localparam int SLW = $bits(t_slot);

    t_state           r_state, n_state;
    logic [MW-1:0]    r_clr, n_clr;
    logic [1:0]       r_opc, n_opc;
    logic [HDL_W-1:0] r_hdl, n_hdl;
    logic [EV_W-1:0]  r_ev, n_ev;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [ID_W-1:0]  r_id, n_id;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_mod, n_mod;
    logic [SW-1:0]    r_idx, n_idx;
    logic [SW-1:0]    r_j, n_j;
    t_slot            r_a, n_a, r_b, n_b, r_c, n_c;
    logic             r_alloc, n_alloc;
    logic             r_hasb, n_hasb;
    logic             r_hasc, n_hasc;
    t_kind            r_kind, n_kind;
    logic [1:0]       r_step, n_step;
    logic             r_flush, n_flush;

    logic             r_ov, n_ov;
    logic             r_status, n_status;
    t_cmd             r_cmd, n_cmd;
    logic [HDL_W-1:0] r_ch, n_ch;
    logic [EV_W-1:0]  r_ce, n_ce;
    logic [TAG_W-1:0] r_ct, n_ct;
    logic             r_last, n_last;

    logic             map_we;
    logic [MW-1:0]    map_waddr, map_raddr;
    logic [CNT_W-1:0] map_wdata, map_rdata;
    logic             slot_we;
    logic [SW-1:0]    slot_waddr, slot_raddr;
    t_slot            slot_wdata, slot_rdata;
    logic [SLW-1:0]   slot_rbits;

    ilcc_ram #(.W(CNT_W), .D(MAX_HANDLES)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    ilcc_ram #(.W(SLW), .D(SLOT_COUNT)) u_slot (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rbits)
    );

    assign slot_rdata = t_slot'(slot_rbits);

    always_comb begin
        logic             hit;
        logic             newly;
        logic [CNT_W-1:0] idx7;
        logic [CNT_W-1:0] m;
        logic [CNT_W-1:0] u;
        t_slot            p;

        n_state  = r_state;
        n_clr    = r_clr;
        n_opc    = r_opc;
        n_hdl    = r_hdl;
        n_ev     = r_ev;
        n_tag    = r_tag;
        n_id     = r_id;
        n_used   = r_used;
        n_mod    = r_mod;
        n_idx    = r_idx;
        n_j      = r_j;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_alloc  = r_alloc;
        n_hasb   = r_hasb;
        n_hasc   = r_hasc;
        n_kind   = r_kind;
        n_step   = r_step;
        n_flush  = r_flush;
        n_ov     = 1'b0;
        n_status = 1'b0;
        n_cmd    = CMD_NONE;
        n_ch     = '0;
        n_ce     = '0;
        n_ct     = '0;
        n_last   = 1'b1;

        map_we     = 1'b0;
        map_waddr  = r_clr;
        map_wdata  = NOSLOT;
        map_raddr  = MW'(i_handle);
        slot_we    = 1'b0;
        slot_waddr = r_idx;
        slot_wdata = r_a;
        slot_raddr = r_idx;

        hit   = (map_rdata < r_used) && (map_rdata < CNT_W'(SLOT_COUNT));
        idx7  = CNT_W'(r_idx);
        newly = (r_a.ckey != {1'b1, r_hdl, r_id}) || (r_a.ctag != r_tag);
        m     = r_mod - 1'b1;
        u     = r_used - 1'b1;
        p     = slot_rdata;

        case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                map_wdata = NOSLOT;
                n_clr     = r_clr + 1'b1;
                if (r_clr == MW'(MAX_HANDLES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_opc   = i_opcode;
                    n_hdl   = i_handle;
                    n_ev    = i_event_mask;
                    n_tag   = i_user_tag;
                    n_id    = i_owner_id;
                    n_flush = 1'b0;
                    if (i_opcode == OPC_FLUSH) begin
                        if (r_mod == '0) begin
                            n_ov = 1'b1;
                        end else begin
                            n_flush = 1'b1;
                            n_state = S_FIDX;
                        end
                    end else if ((i_opcode == OPC_ASSOC && !i_already_fired) ||
                                 i_opcode == OPC_DISSOC) begin
                        if (32'(i_handle) < MAX_HANDLES) begin
                            n_state = S_MAP;
                        end else begin
                            n_ov     = 1'b1;
                            n_status = (i_opcode == OPC_ASSOC);
                        end
                    end else begin
                        n_ov = 1'b1;
                    end
                end
            end
            S_MAP: begin
                n_alloc = 1'b0;
                if (hit) begin
                    slot_raddr = SW'(map_rdata);
                    n_idx      = SW'(map_rdata);
                    n_state    = S_RDA;
                end else if (r_opc == OPC_ASSOC && r_used < CNT_W'(SLOT_COUNT)) begin
                    // take a fresh slot at the end of the table
                    n_idx   = SW'(r_used);
                    n_used  = r_used + 1'b1;
                    n_alloc = 1'b1;
                    n_a     = '0;
                    n_a.ph  = r_hdl;
                    n_a.pop = CMD_NONE;
                    n_state = S_DEC;
                end else begin
                    n_ov     = 1'b1;
                    n_status = (r_opc == OPC_ASSOC);
                    n_state  = S_IDLE;
                end
            end
            S_RDA: begin
                n_a     = slot_rdata;
                n_state = S_DEC;
            end
            S_DEC: begin
                n_step = '0;
                if (r_opc == OPC_ASSOC) begin
                    if (newly || r_a.cev != r_ev) begin
                        n_a.ph   = r_hdl;
                        n_a.pid  = r_id;
                        n_a.pev  = r_ev;
                        n_a.ptag = r_tag;
                        n_a.pop  = newly ? CMD_ADD : CMD_MOD;
                        if (idx7 > r_mod) begin
                            n_j        = SW'(r_mod);
                            slot_raddr = SW'(r_mod);
                            n_kind     = K_SWAP;
                            n_mod      = r_mod + 1'b1;
                            n_state    = S_RDB;
                        end else begin
                            n_kind  = K_WRA;
                            if (idx7 == r_mod) begin
                                n_mod = r_mod + 1'b1;
                            end
                            n_state = S_WR;
                        end
                    end else if (idx7 < r_mod && r_a.pop == CMD_DEL) begin
                        // cancel the pending delete: move the slot out of the prefix
                        n_mod = m;
                        if (idx7 < m) begin
                            n_j        = SW'(m);
                            slot_raddr = SW'(m);
                            n_kind     = K_SWAP;
                            n_state    = S_RDB;
                        end else begin
                            n_ov    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_ov    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    if (idx7 < r_mod && r_a.pop == CMD_ADD) begin
                        // drop a slot whose add never went out
                        n_mod  = m;
                        n_used = u;
                        n_j    = SW'(m);
                        n_kind = K_DROP;
                        n_hasb = (idx7 < m);
                        n_hasc = (m < u);
                        if (idx7 < m) begin
                            slot_raddr = SW'(m);
                            n_state    = S_RDB;
                        end else if (m < u) begin
                            slot_raddr = SW'(u);
                            n_state    = S_RDC;
                        end else begin
                            n_state = S_WR;
                        end
                    end else begin
                        n_a.pop = CMD_DEL;
                        if (idx7 > r_mod) begin
                            n_j        = SW'(r_mod);
                            slot_raddr = SW'(r_mod);
                            n_kind     = K_SWAP;
                            n_mod      = r_mod + 1'b1;
                            n_state    = S_RDB;
                        end else begin
                            n_kind  = K_WRA;
                            if (idx7 == r_mod) begin
                                n_mod = r_mod + 1'b1;
                            end
                            n_state = S_WR;
                        end
                    end
                end
            end
            S_RDB: begin
                n_b    = slot_rdata;
                n_step = '0;
                if (r_kind == K_DROP && r_hasc) begin
                    slot_raddr = SW'(r_used);
                    n_state    = S_RDC;
                end else begin
                    n_state = S_WR;
                end
            end
            S_RDC: begin
                n_c     = slot_rdata;
                n_step  = '0;
                n_state = S_WR;
            end
            S_WR: begin
                case (r_kind)
                    K_WRA: begin
                        if (r_step == 2'd0) begin
                            slot_we    = 1'b1;
                            slot_waddr = r_idx;
                            slot_wdata = r_a;
                            map_we     = r_alloc;
                            map_waddr  = MW'(r_hdl);
                            map_wdata  = CNT_W'(r_idx);
                        end
                    end
                    K_SWAP: begin
                        if (r_step == 2'd0) begin
                            slot_we    = 1'b1;
                            slot_waddr = r_j;
                            slot_wdata = r_a;
                            map_we     = 1'b1;
                            map_waddr  = MW'(r_a.ph);
                            map_wdata  = CNT_W'(r_j);
                        end else if (r_step == 2'd1) begin
                            slot_we    = 1'b1;
                            slot_waddr = r_idx;
                            slot_wdata = r_b;
                            map_we     = 1'b1;
                            map_waddr  = MW'(r_b.ph);
                            map_wdata  = CNT_W'(r_idx);
                        end
                    end
                    K_DROP: begin
                        if (r_step == 2'd0) begin
                            map_we    = 1'b1;
                            map_waddr = MW'(r_a.ph);
                            map_wdata = NOSLOT;
                            if (r_hasb) begin
                                slot_we    = 1'b1;
                                slot_waddr = r_idx;
                                slot_wdata = r_b;
                            end else if (r_hasc) begin
                                slot_we    = 1'b1;
                                slot_waddr = r_j;
                                slot_wdata = r_c;
                            end
                        end else if (r_step == 2'd1) begin
                            map_we     = r_hasb;
                            map_waddr  = MW'(r_b.ph);
                            map_wdata  = CNT_W'(r_idx);
                            slot_we    = r_hasb && r_hasc;
                            slot_waddr = r_j;
                            slot_wdata = r_c;
                        end else begin
                            map_we    = r_hasc;
                            map_waddr = MW'(r_c.ph);
                            map_wdata = CNT_W'(r_j);
                        end
                    end
                    default: begin
                    end
                endcase
                n_step = r_step + 1'b1;
                if (r_step == 2'd2) begin
                    n_step = '0;
                    if (r_flush) begin
                        n_state = (r_mod != '0) ? S_FIDX : S_IDLE;
                    end else begin
                        n_ov    = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_FIDX: begin
                n_mod      = m;
                n_idx      = SW'(m);
                slot_raddr = SW'(m);
                n_state    = S_FRD;
            end
            S_FRD: begin
                n_ov    = 1'b1;
                n_cmd   = p.pop;
                n_ch    = p.ph;
                n_last  = (r_mod == '0);
                n_a     = p;
                n_alloc = 1'b0;
                n_step  = '0;
                if (p.pop != CMD_DEL) begin
                    // commit the pending copy
                    n_ce     = p.pev;
                    n_ct     = p.ptag;
                    n_a.ckey = {1'b1, p.ph, p.pid};
                    n_a.cev  = p.pev;
                    n_a.ctag = p.ptag;
                    n_kind   = K_WRA;
                    n_state  = S_WR;
                end else begin
                    n_used = u;
                    n_kind = K_DROP;
                    n_j    = r_idx;
                    n_hasb = 1'b0;
                    n_hasc = (idx7 < u);
                    if (idx7 < u) begin
                        slot_raddr = SW'(u);
                        n_state    = S_RDC;
                    end else begin
                        n_state = S_WR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_used  <= '0;
            r_mod   <= '0;
            r_step  <= '0;
            r_flush <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_used  <= n_used;
            r_mod   <= n_mod;
            r_step  <= n_step;
            r_flush <= n_flush;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opc    <= n_opc;
        r_hdl    <= n_hdl;
        r_ev     <= n_ev;
        r_tag    <= n_tag;
        r_id     <= n_id;
        r_idx    <= n_idx;
        r_j      <= n_j;
        r_a      <= n_a;
        r_b      <= n_b;
        r_c      <= n_c;
        r_alloc  <= n_alloc;
        r_hasb   <= n_hasb;
        r_hasc   <= n_hasc;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_cmd    <= n_cmd;
        r_ch     <= n_ch;
        r_ce     <= n_ce;
        r_ct     <= n_ct;
        r_last   <= n_last;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_ov;
    assign o_status     = r_status;
    assign o_command    = r_cmd;
    assign o_cmd_handle = r_ch;
    assign o_cmd_events = r_ce;
    assign o_cmd_tag    = r_ct;
    assign o_last       = r_last;

    `ILCC_ASSERT(a_mod_le_used, i_clk, i_rst_n, r_mod <= r_used)
    `ILCC_ASSERT(a_used_le_cap, i_clk, i_rst_n, r_used <= CNT_W'(SLOT_COUNT))
    `ILCC_ASSERT_IMP(a_no_result_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_valid)
    `ILCC_ASSERT_IMP(a_flush_mod_drop, i_clk, i_rst_n, r_state == S_FIDX, r_mod != '0)

endmodule
